// ----- rtl/core/lsc_pkg.sv -----
// shared types and constants of the lsb steganography codec
package lsc_pkg;

  localparam int MESSAGE_DEPTH_DEF = 256;
  localparam int CFG_IDX_W         = 4;
  localparam int HDR_CNT_W         = 4;

  localparam logic [HDR_CNT_W-1:0] HDR_BITS      = 4'd8;
  localparam logic [7:0]           LSB_CLEAR_MASK = 8'hFE;
  localparam logic [2:0]           LAST_BIT_POS   = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MSG_LEN = 4'd1;

  localparam logic MODE_EMBED   = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_IMAGE = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic       first_of_image;
    logic       padding;
    logic [7:0] msg_index;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       char_valid;
    logic [7:0] char_value;
    logic [7:0] char_index;
    logic [7:0] decoded_length;
    logic       finished;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           wdata;
  } cfg_wr_t;

endpackage

// ----- rtl/core/lsc_stream_if.sv -----
// valid/ready channel carrying one payload beat
interface lsc_stream_if #(
  parameter type payload_t = logic [7:0]
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/lsc_ram.sv -----
// generic single-write, single-read ram with registered read data
module lsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- rtl/core/lsb_stego_codec_top.sv -----
// lsb steganography codec: embeds or extracts a length-prefixed message in image byte lsbs
//
// in_ch beats are either message loads (opcode load: data goes to store entry
// msg_index, no result) or image bytes (one out_ch beat each). cfg_ch writes
// register 0 (mode) or 1 (message length); it is always ready. The user must see
// that it is only written while the codec is idle; the codec does not enforce it.
// The message store is a ram read at the character counter when an image beat
// is accepted; its registered read data is merged in the next cycle, and the
// merged result is registered in the output register that drives out_ch.
// Throughput is one beat per cycle while out_ch does not stall: the counters
// and header logic update in the accept cycle, only the store read is
// pipelined, and one store read port is used per image beat.
// While out_ch stalls one more image beat is taken into the read stage; after
// that in_ch.ready drops until out_ch moves again.
// Synchronous reset clears counters, config and pipeline valids; the store
// contents are undefined until loaded, and no clearing pass is needed.
module lsb_stego_codec_top #(
  parameter int MESSAGE_DEPTH = lsc_pkg::MESSAGE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  lsc_stream_if.sink    in_ch,
  lsc_stream_if.source  out_ch,
  lsc_stream_if.sink    cfg_ch
);
  import lsc_pkg::*;

  localparam int          AW      = $clog2(MESSAGE_DEPTH);
  localparam logic [31:0] DEPTH_W = 32'(MESSAGE_DEPTH);

  in_item_t  in_item;
  cfg_wr_t   cfg_item;

  logic                 mode_r;
  logic [7:0]           msg_len_r;
  logic [HDR_CNT_W-1:0] hb_r, hb_e, hb_nxt;
  logic [2:0]           bp_r, bp_e, bp_nxt;
  logic [7:0]           cc_r, cc_e, cc_nxt;
  logic [7:0]           sr_r, sr_e, sr_nxt;
  logic [7:0]           lr_r, lr_e, lr_nxt;

  logic       acc, img_acc, load_acc;
  logic       use_ram, cvalid, fin;
  logic [7:0] ob_pre, base, limit;

  logic       s1_valid_r, s1_use_ram_r, s1_rng_r;
  logic [2:0] s1_bit_r;
  out_item_t  s1_item_r, s1_item_nxt;
  logic       s1_adv;

  logic       out_valid_r;
  out_item_t  out_item_r, out_item_nxt;

  logic [AW+7:0] widx, ridx;
  logic [7:0]    ram_rdata;
  logic          ram_we, ram_re, rd_rng, ram_bit;

  assign in_item  = in_ch.payload;
  assign cfg_item = cfg_ch.payload;

  // config port
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_EMBED;
      msg_len_r <= 8'd0;
    end else if (cfg_ch.valid) begin
      case (cfg_item.index)
        CFG_MODE:    mode_r    <= cfg_item.wdata[0];
        CFG_MSG_LEN: msg_len_r <= cfg_item.wdata;
        default:     ;
      endcase
    end
  end

  // handshake
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign acc         = in_ch.valid && in_ch.ready;
  assign img_acc     = acc && (in_item.opcode == OP_IMAGE);
  assign load_acc    = acc && (in_item.opcode == OP_LOAD);

  // counter and header logic
  always_comb begin
    hb_e = in_item.first_of_image ? '0 : hb_r;
    bp_e = in_item.first_of_image ? '0 : bp_r;
    cc_e = in_item.first_of_image ? '0 : cc_r;
    sr_e = in_item.first_of_image ? '0 : sr_r;
    lr_e = in_item.first_of_image ? '0 : lr_r;
    hb_nxt  = hb_e;
    bp_nxt  = bp_e;
    cc_nxt  = cc_e;
    sr_nxt  = sr_e;
    lr_nxt  = lr_e;
    ob_pre  = in_item.data;
    use_ram = 1'b0;
    cvalid  = 1'b0;
    base    = 8'd0;
    if (!in_item.padding) begin
      if (mode_r == MODE_EMBED) begin
        if (hb_e < HDR_BITS) begin
          ob_pre = (in_item.data & LSB_CLEAR_MASK) | {7'd0, msg_len_r[hb_e[2:0]]};
          hb_nxt = hb_e + 4'd1;
        end else if (cc_e < msg_len_r) begin
          use_ram = 1'b1;
          if (bp_e == LAST_BIT_POS) begin
            bp_nxt = 3'd0;
            cc_nxt = cc_e + 8'd1;
          end else begin
            bp_nxt = bp_e + 3'd1;
          end
        end
      end else begin
        if (hb_e < HDR_BITS) begin
          lr_nxt = lr_e | (8'(in_item.data[0]) << hb_e[2:0]);
          hb_nxt = hb_e + 4'd1;
        end else if (cc_e < lr_e) begin
          base   = (bp_e == 3'd0) ? 8'd0 : sr_e;
          sr_nxt = base | (8'(in_item.data[0]) << bp_e);
          if (bp_e == LAST_BIT_POS) begin
            cvalid = 1'b1;
            bp_nxt = 3'd0;
            cc_nxt = cc_e + 8'd1;
          end else begin
            bp_nxt = bp_e + 3'd1;
          end
        end
      end
    end
    limit = (mode_r == MODE_EMBED) ? msg_len_r : lr_nxt;
    fin   = (hb_nxt >= HDR_BITS) && (cc_nxt >= limit);

    s1_item_nxt.out_byte       = ob_pre;
    s1_item_nxt.char_valid     = cvalid;
    s1_item_nxt.char_value     = cvalid ? sr_nxt : 8'd0;
    s1_item_nxt.char_index     = cvalid ? cc_e : 8'd0;
    s1_item_nxt.decoded_length = (mode_r == MODE_EMBED) ? 8'd0 : lr_nxt;
    s1_item_nxt.finished       = fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hb_r <= '0;
      bp_r <= '0;
      cc_r <= '0;
      sr_r <= '0;
      lr_r <= '0;
    end else if (img_acc) begin
      hb_r <= hb_nxt;
      bp_r <= bp_nxt;
      cc_r <= cc_nxt;
      sr_r <= sr_nxt;
      lr_r <= lr_nxt;
    end
  end

  // message store
  assign widx    = {{AW{1'b0}}, in_item.msg_index};
  assign ridx    = {{AW{1'b0}}, cc_e};
  assign ram_we  = load_acc && ({24'd0, in_item.msg_index} < DEPTH_W);
  assign ram_re  = img_acc && use_ram;
  assign rd_rng  = {24'd0, cc_e} < DEPTH_W;

  lsc_ram #(
    .WIDTH (8),
    .DEPTH (MESSAGE_DEPTH)
  ) u_msg_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (widx[AW-1:0]),
    .wdata (in_item.data),
    .re    (ram_re),
    .raddr (ridx[AW-1:0]),
    .rdata (ram_rdata)
  );

  // read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (img_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (img_acc) begin
      s1_item_r    <= s1_item_nxt;
      s1_use_ram_r <= use_ram;
      s1_bit_r     <= bp_e;
      s1_rng_r     <= rd_rng;
    end
  end

  // merge store bit and output register
  assign ram_bit = ram_rdata[s1_bit_r] & s1_rng_r;

  always_comb begin
    out_item_nxt = s1_item_r;
    if (s1_use_ram_r) begin
      out_item_nxt.out_byte = (s1_item_r.out_byte & LSB_CLEAR_MASK) | {7'd0, ram_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_item_r;

`ifndef NO_ASSERTIONS
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while both stages are full");

  a_hdr_range: assert property (@(posedge clk) disable iff (!rst_n)
    hb_r <= HDR_BITS)
    else $error("header bit count out of range");

  a_char_step: assert property (@(posedge clk) disable iff (!rst_n)
    (img_acc && cvalid) |=> (bp_r == 3'd0 && cc_r == $past(cc_e + 8'd1)))
    else $error("character completion did not advance counters");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (load_acc && !s1_valid_r) |=> !s1_valid_r)
    else $error("load beat produced a result");
`endif
endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// testbench for the lsb steganography codec: drives loads and image beats, checks results
module tb_top;
  import lsc_pkg::*;

  localparam int DEPTH        = MESSAGE_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1000;

  typedef enum {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_kind_e;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  lsc_stream_if #(.payload_t(in_item_t))  in_if ();
  lsc_stream_if #(.payload_t(out_item_t)) out_if ();
  lsc_stream_if #(.payload_t(cfg_wr_t))   cfg_if ();

  lsb_stego_codec_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [7:0]           msg_mem [DEPTH];
  logic [HDR_CNT_W-1:0] hdr_done   = '0;
  logic [2:0]           bit_pos    = '0;
  logic [7:0]           char_cnt   = '0;
  logic [7:0]           char_shift = '0;
  logic [7:0]           len_hdr    = '0;
  logic                 cur_mode   = MODE_EMBED;
  logic [7:0]           cur_len    = '0;

  out_item_t predicted_out [$];

  int errors     = 0;
  int items_sent = 0;
  int burst_left = 0;
  int gap_max    = 4;
  int hold_req   = 0;
  int hold_left  = 0;
  int rx_left    = 0;
  int rx_count   = 0;
  rx_kind_e rx_kind = RX_OPEN;

  task automatic stego_predict(input in_item_t it);
    out_item_t r;
    logic [7:0] ch;
    logic [7:0] base;
    logic       took_bit;
    if (it.opcode == OP_LOAD) begin
      msg_mem[it.msg_index] = it.data;
    end else begin
      r = '0;
      took_bit = 1'b0;
      r.out_byte = it.data;
      if (it.first_of_image) begin
        hdr_done   = '0;
        bit_pos    = '0;
        char_cnt   = '0;
        char_shift = '0;
        len_hdr    = '0;
      end
      if (!it.padding) begin
        if (cur_mode == MODE_EMBED) begin
          if (hdr_done < HDR_BITS) begin
            r.out_byte = (it.data & LSB_CLEAR_MASK) | 8'(cur_len[hdr_done[2:0]]);
            hdr_done++;
          end else if (char_cnt < cur_len) begin
            ch = msg_mem[char_cnt];
            r.out_byte = (it.data & LSB_CLEAR_MASK) | 8'(ch[bit_pos]);
            took_bit = 1'b1;
          end
        end else begin
          if (hdr_done < HDR_BITS) begin
            len_hdr[hdr_done[2:0]] = len_hdr[hdr_done[2:0]] | it.data[0];
            hdr_done++;
          end else if (char_cnt < len_hdr) begin
            base = (bit_pos == 3'd0) ? 8'h00 : char_shift;
            char_shift = base | (8'(it.data[0]) << bit_pos);
            if (bit_pos == LAST_BIT_POS) begin
              r.char_valid = 1'b1;
              r.char_value = char_shift;
              r.char_index = char_cnt;
            end
            took_bit = 1'b1;
          end
        end
        if (took_bit) begin
          if (bit_pos == LAST_BIT_POS) begin
            bit_pos = '0;
            char_cnt++;
          end else begin
            bit_pos++;
          end
        end
      end
      r.decoded_length = (cur_mode == MODE_EXTRACT) ? len_hdr : 8'h00;
      r.finished = (hdr_done >= HDR_BITS) &&
                   (char_cnt >= ((cur_mode == MODE_EMBED) ? cur_len : len_hdr));
      predicted_out.push_back(r);
    end
  endtask

  function automatic in_item_t mk_image(input bit first, input bit pad, input logic [7:0] data);
    in_item_t it;
    it.opcode         = OP_IMAGE;
    it.first_of_image = first;
    it.padding        = pad;
    it.msg_index      = 8'($urandom);
    it.data           = data;
    return it;
  endfunction

  function automatic in_item_t mk_load(input logic [7:0] idx, input logic [7:0] data);
    in_item_t it;
    it.opcode         = OP_LOAD;
    it.first_of_image = 1'($urandom);
    it.padding        = 1'($urandom);
    it.msg_index      = idx;
    it.data           = data;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    if (burst_left == 0) begin
      repeat ($urandom_range(gap_max, 0)) begin
        @(negedge clk);
        in_if.valid = 1'b0;
      end
      burst_left = $urandom_range(40, 1);
    end
    burst_left--;
    @(negedge clk);
    in_if.valid   = 1'b1;
    in_if.payload = it;
    do @(posedge clk); while (!in_if.ready);
    stego_predict(it);
    items_sent++;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_if.valid = 1'b0;
    burst_left  = 0;
    while (predicted_out.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    @(negedge clk);
    cfg_if.valid         = 1'b1;
    cfg_if.payload.index = idx;
    cfg_if.payload.wdata = value;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == CFG_MODE) cur_mode = value[0];
    else if (idx == CFG_MSG_LEN) cur_len = value;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic set_config(input logic mode, input logic [7:0] len);
    wait_drain();
    write_cfg(CFG_MODE, 8'(mode));
    write_cfg(CFG_MSG_LEN, len);
  endtask

  // one image beat per bit, lsb first; optional padding and loads mixed in
  task automatic send_bits(input logic [7:0] value, input int nbits, input bit first,
                           input bit mix);
    bit fst;
    fst = first;
    for (int i = 0; i < nbits; i++) begin
      if (mix && $urandom_range(9, 0) == 0) begin
        send_item(mk_image(fst, 1'b1, 8'($urandom)));
        fst = 1'b0;
      end
      if (mix && $urandom_range(19, 0) == 0)
        send_item(mk_load(8'($urandom), 8'($urandom)));
      send_item(mk_image(fst, 1'b0, {7'($urandom), value[i]}));
      fst = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (predicted_out.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat: expected none, actual %p", $time, out_if.payload);
      end else begin
        want = predicted_out.pop_front();
        check_field("out_byte", want.out_byte, out_if.payload.out_byte);
        check_field("char_valid", 8'(want.char_valid), 8'(out_if.payload.char_valid));
        check_field("char_value", want.char_value, out_if.payload.char_value);
        check_field("char_index", want.char_index, out_if.payload.char_index);
        check_field("decoded_length", want.decoded_length, out_if.payload.decoded_length);
        check_field("finished", 8'(want.finished), 8'(out_if.payload.finished));
      end
    end
  end

  // receiver stall pattern, with long hold-offs on request
  always @(negedge clk) begin
    rx_count++;
    if (hold_left > 0) begin
      out_if.ready = 1'b0;
      hold_left--;
    end else if (hold_req > 0) begin
      out_if.ready = 1'b0;
      hold_left    = hold_req - 1;
      hold_req     = 0;
    end else begin
      if (rx_left == 0) begin
        rx_kind = rx_kind_e'($urandom_range(3, 0));
        rx_left = $urandom_range(150, 30);
      end
      rx_left--;
      case (rx_kind)
        RX_OPEN:   out_if.ready = 1'b1;
        RX_MOSTLY: out_if.ready = ($urandom_range(3, 0) != 0);
        RX_SPARSE: out_if.ready = ($urandom_range(3, 0) == 0);
        default:   out_if.ready = (rx_count % 3 == 0);
      endcase
    end
  end

  task automatic test_store_fill();
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0)      send_item(mk_load(8'(i), 8'h00));
      else if (i == 1) send_item(mk_load(8'(i), 8'hFF));
      else             send_item(mk_load(8'(i), 8'($urandom)));
    end
  endtask

  task automatic test_embed_basics();
    set_config(MODE_EMBED, 8'd1);
    send_item(mk_image(1'b1, 1'b1, 8'hFF));
    for (int i = 0; i < 8; i++) begin
      send_item(mk_image(1'b0, 1'b0, (i % 2 == 0) ? 8'h00 : 8'hFF));
      if (i == 3) send_item(mk_image(1'b0, 1'b1, 8'h00));
    end
    send_bits(8'($urandom), 4, 1'b0, 1'b0);
    send_item(mk_load(8'h00, 8'h5A));
    send_bits(8'($urandom), 4, 1'b0, 1'b0);
    send_bits(8'($urandom), 2, 1'b0, 1'b0);
  endtask

  task automatic test_extract_basics();
    set_config(MODE_EXTRACT, 8'hFF);
    send_bits(8'd1, 8, 1'b1, 1'b0);
    send_bits(8'hA7, 8, 1'b0, 1'b0);
    send_bits(8'($urandom), 1, 1'b0, 1'b0);
  endtask

  // shortened length, mode switch without restart, zero length
  task automatic test_length_and_mode_change();
    set_config(MODE_EMBED, 8'd2);
    send_bits(8'($urandom), 16, 1'b1, 1'b0);
    set_config(MODE_EMBED, 8'd1);
    send_bits(8'($urandom), 2, 1'b0, 1'b0);
    set_config(MODE_EXTRACT, 8'd1);
    send_bits(8'($urandom), 2, 1'b0, 1'b0);
    set_config(MODE_EMBED, 8'd0);
    send_bits(8'($urandom), 10, 1'b1, 1'b0);
  endtask

  task automatic test_random_frames();
    int start = items_sent;
    int phase = 0;
    int len;
    int nchar;
    bit extract;
    in_item_t it;
    while (items_sent < start + RANDOM_ITEMS) begin
      extract = 1'($urandom);
      case ($urandom_range(9, 0))
        0:       len = 0;
        1:       len = 255;
        default: len = $urandom_range(6, 1);
      endcase
      gap_max = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      set_config(extract ? MODE_EXTRACT : MODE_EMBED, 8'(len));
      if (phase == 3) hold_req = 400;
      if (phase != 3 && $urandom_range(7, 0) == 0) begin
        repeat (30) begin
          it = mk_image(($urandom_range(7, 0) == 0), 1'($urandom), 8'($urandom));
          if ($urandom_range(3, 0) == 0) it = mk_load(8'($urandom), 8'($urandom));
          send_item(it);
        end
      end else begin
        nchar = (len > 8) ? $urandom_range(4, 1) : len;
        send_bits(8'(len), 8, 1'b1, 1'b1);
        for (int c = 0; c < nchar; c++) send_bits(8'($urandom), 8, 1'b0, 1'b1);
        if ($urandom_range(5, 0) == 0) send_bits(8'($urandom), $urandom_range(7, 1), 1'b0, 1'b1);
        send_bits(8'($urandom), $urandom_range(3, 0), 1'b0, 1'b1);
      end
      phase++;
    end
  endtask

  initial begin
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    out_if.ready   = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_store_fill();
    test_embed_basics();
    test_extract_basics();
    test_length_and_mode_change();
    test_random_frames();
    wait_drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && predicted_out.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- lsb_stego_codec_top.f -----
rtl/core/lsc_pkg.sv
rtl/core/lsc_stream_if.sv
rtl/core/lsc_ram.sv
rtl/core/lsb_stego_codec_top.sv
tb/sv/tb_top.sv
